[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands on clk with asynchronous reset arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)

`endif

`endif

[src/lpht_pkg.sv]
// ----------------------------------------------------------------------------
// lpht_pkg
// Sizes, operation and status codes, and hash constants of the probe table.
// ----------------------------------------------------------------------------
package lpht_pkg;

	// Slot count; a power of two, so the home slot is the low hash bits.
	localparam int TABLE_SIZE = 256;
	localparam int SLOT_W     = $clog2(TABLE_SIZE);
	localparam int CNT_W      = SLOT_W + 1;

	localparam int KIND_W   = 2;
	localparam int KEY_W    = 64;
	localparam int VAL_W    = 64;
	localparam int STATUS_W = 2;
	localparam int ENTRY_W  = 9;

	localparam int                 MUL_W      = 27;
	localparam logic [MUL_W-1:0]   HASH_MUL   = 27'h45d9f3b;
	localparam int                 HASH_SHIFT = 16;
	localparam int                 HALF_W     = KEY_W / 2;

	localparam logic [KIND_W-1:0] OP_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] OP_LOOKUP = 2'd1;
	localparam logic [KIND_W-1:0] OP_REMOVE = 2'd2;

	localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

	typedef struct packed {
		logic              done;
		logic [SLOT_W-1:0] slot;
	} hash_res_t;

endpackage

[src/lpht_hash.sv]
// ----------------------------------------------------------------------------
// lpht_hash
// Two-round xor-shift-multiply hash of a 64-bit key on one shared 32x27
// multiplier; each round multiplies the low half, then the high half.
// ----------------------------------------------------------------------------
module lpht_hash (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [lpht_pkg::KEY_W-1:0] key,
	output lpht_pkg::hash_res_t     res
);
	import lpht_pkg::*;

	typedef enum logic [1:0] {H_IDLE, H_LO, H_HI} hstate_t;

	hstate_t                   state_q;
	logic                      round_q;
	logic                      done_q;
	logic [KEY_W-1:0]          x_q;
	logic [KEY_W-1:0]          acc_q;
	logic [HALF_W-1:0]         mul_in;
	logic [HALF_W+MUL_W-1:0]   prod;
	logic [KEY_W-1:0]          sum;

	assign mul_in = (state_q == H_LO) ? x_q[HALF_W-1:0] : x_q[KEY_W-1:HALF_W];
	assign prod   = mul_in * HASH_MUL;
	// High half product only lands in the upper word (mod 2^64).
	assign sum    = {acc_q[KEY_W-1:HALF_W] + prod[HALF_W-1:0], acc_q[HALF_W-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
			round_q <= 1'b0;
			done_q  <= 1'b0;
			x_q     <= '0;
			acc_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				H_IDLE: begin
					if (start) begin
						x_q     <= key ^ (key >> HASH_SHIFT);
						round_q <= 1'b0;
						state_q <= H_LO;
					end
				end
				H_LO: begin
					acc_q   <= KEY_W'(prod);
					state_q <= H_HI;
				end
				H_HI: begin
					x_q <= sum ^ (sum >> HASH_SHIFT);
					if (round_q) begin
						done_q  <= 1'b1;
						state_q <= H_IDLE;
					end else begin
						round_q <= 1'b1;
						state_q <= H_LO;
					end
				end
				default: state_q <= H_IDLE;
			endcase
		end
	end

	assign res.done = done_q;
	assign res.slot = x_q[SLOT_W-1:0];

endmodule

[src/linear_probe_hash_table.sv]
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing key/value table with linear probing over a synchronous
// key/value RAM and flip-flop valid bits.
// ----------------------------------------------------------------------------
// Unused kind or insert into a full table goes straight to the result; otherwise
// the key is hashed (4 multiplier steps) and then probed.
// Insert probes the valid bits one slot a cycle until it finds a free slot.
// Lookup/remove read one RAM slot a cycle until a hit or, on a miss, until all
// TABLE_SIZE (256) slots have been read. One request in flight at a time.
// Reset clears valid bits and the entry count at once; no clearing pass.
module linear_probe_hash_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [lpht_pkg::KIND_W-1:0]   kind,
	input  logic [lpht_pkg::KEY_W-1:0]    key,
	input  logic [lpht_pkg::VAL_W-1:0]    value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [lpht_pkg::STATUS_W-1:0] status,
	output logic [lpht_pkg::VAL_W-1:0]    found_value,
	output logic [lpht_pkg::ENTRY_W-1:0]  entries_used
);
	import lpht_pkg::*;

	`include "assert_macros.svh"

	typedef enum logic [1:0] {S_IDLE, S_HASH, S_PROBE, S_DONE} state_t;

	state_t                  state_q;
	logic [KIND_W-1:0]       kind_q;
	logic [KEY_W-1:0]        key_q;
	logic [VAL_W-1:0]        value_q;
	logic [SLOT_W-1:0]       pos_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [CNT_W-1:0]        used_q;
	logic [TABLE_SIZE-1:0]   slot_valid_q;
	logic                    rd_s1;
	logic                    vld_s1;
	logic                    last_s1;
	logic [SLOT_W-1:0]       pos_s1;
	logic [KEY_W+VAL_W-1:0]  rdata_s1;
	logic [STATUS_W-1:0]     pend_status_q;
	logic [VAL_W-1:0]        pend_found_q;
	logic                    out_valid_q;
	logic [STATUS_W-1:0]     status_q;
	logic [VAL_W-1:0]        found_q;
	logic [ENTRY_W-1:0]      entries_q;

	logic [KEY_W+VAL_W-1:0]  table_mem [TABLE_SIZE];

	logic                    accept;
	logic                    is_full;
	logic                    hash_start;
	logic                    mem_we;
	logic                    issue;
	logic                    hit;
	logic                    out_free;
	hash_res_t               hash_res;

	assign in_ready   = (state_q == S_IDLE);
	assign accept     = in_valid && in_ready;
	assign is_full    = (used_q == CNT_W'(TABLE_SIZE));
	assign hash_start = accept && (((kind == OP_INSERT) && !is_full) ||
		(kind == OP_LOOKUP) || (kind == OP_REMOVE));
	assign mem_we     = (state_q == S_PROBE) && (kind_q == OP_INSERT) && !slot_valid_q[pos_q];
	assign issue      = (state_q == S_PROBE) && (kind_q != OP_INSERT) &&
		(cnt_q != CNT_W'(TABLE_SIZE));
	assign hit        = rd_s1 && vld_s1 && (rdata_s1[KEY_W+VAL_W-1:VAL_W] == key_q);
	assign out_free   = !out_valid_q || out_ready;

	lpht_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.key    (key),
		.res    (hash_res)
	);

	// Key/value RAM: one write port, one registered read port, both at pos_q.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			table_mem[pos_q] <= {key_q, value_q};
		end
		rdata_s1 <= table_mem[pos_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			kind_q        <= OP_INSERT;
			key_q         <= '0;
			value_q       <= '0;
			pos_q         <= '0;
			cnt_q         <= '0;
			used_q        <= '0;
			slot_valid_q  <= '0;
			rd_s1         <= 1'b0;
			vld_s1        <= 1'b0;
			last_s1       <= 1'b0;
			pos_s1        <= '0;
			pend_status_q <= ST_DONE;
			pend_found_q  <= '0;
			out_valid_q   <= 1'b0;
			status_q      <= ST_DONE;
			found_q       <= '0;
			entries_q     <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						kind_q  <= kind;
						key_q   <= key;
						value_q <= value;
						if (hash_start) begin
							state_q <= S_HASH;
						end else begin
							// Unused kind, or insert into a full table
							pend_status_q <= (kind == OP_INSERT) ? ST_FULL : ST_DONE;
							pend_found_q  <= '0;
							state_q       <= S_DONE;
						end
					end
				end
				S_HASH: begin
					if (hash_res.done) begin
						pos_q   <= hash_res.slot;
						cnt_q   <= '0;
						rd_s1   <= 1'b0;
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					if (kind_q == OP_INSERT) begin
						if (!slot_valid_q[pos_q]) begin
							slot_valid_q[pos_q] <= 1'b1;
							used_q              <= used_q + CNT_W'(1);
							pend_status_q       <= ST_DONE;
							pend_found_q        <= '0;
							state_q             <= S_DONE;
						end else begin
							pos_q <= pos_q + SLOT_W'(1);
						end
					end else begin
						rd_s1   <= issue;
						vld_s1  <= slot_valid_q[pos_q];
						pos_s1  <= pos_q;
						last_s1 <= (cnt_q == CNT_W'(TABLE_SIZE - 1));
						if (issue) begin
							pos_q <= pos_q + SLOT_W'(1);
							cnt_q <= cnt_q + CNT_W'(1);
						end
						if (hit) begin
							if (kind_q == OP_REMOVE) begin
								slot_valid_q[pos_s1] <= 1'b0;
								used_q               <= used_q - CNT_W'(1);
								pend_found_q         <= '0;
							end else begin
								pend_found_q <= rdata_s1[VAL_W-1:0];
							end
							pend_status_q <= ST_DONE;
							rd_s1         <= 1'b0;
							state_q       <= S_DONE;
						end else if (rd_s1 && last_s1) begin
							// Whole ring read without a match
							pend_status_q <= ST_NOT_FOUND;
							pend_found_q  <= '0;
							rd_s1         <= 1'b0;
							state_q       <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						status_q    <= pend_status_q;
						found_q     <= pend_found_q;
						entries_q   <= ENTRY_W'(used_q);
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign found_value  = found_q;
	assign entries_used = entries_q;

	`ASSERT_IMPLY(a_count_matches_valid, 1'b1, CNT_W'($countones(slot_valid_q)) == used_q)
	`ASSERT_IMPLY(a_hash_done_in_wait, hash_res.done, state_q == S_HASH)
	`ASSERT_IMPLY(a_write_only_insert, mem_we, (kind_q == OP_INSERT) && !is_full)
	`ASSERT_NEXT(a_done_loads_output, (state_q == S_DONE) && out_free, out_valid && (state_q == S_IDLE))

endmodule
